@@ src/alkt_pkg.sv @@
// ----------------------------------------------------------------------------
// alkt_pkg: shared types and helpers of the associative key table
// Request and response layouts, action codes, entry layout and the
// saturating counter step used by the statistics.
// ----------------------------------------------------------------------------
package alkt_pkg;

    // default number of table slots
    localparam int ENTRIES_DEF = 8;

    localparam int KEY_W   = 64;
    localparam int CNT_W   = 32;
    localparam int STAMP_W = 64;

    // action codes
    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_STORE  = 2'd1;
    localparam logic [1:0] ACT_INVAL  = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [1:0]       action;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] token_count;
    } t_req;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] found_count;
        logic [2:0]       slot_index;
        logic             evicted;
        logic [CNT_W-1:0] lookup_total;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] store_total;
        logic [CNT_W-1:0] eviction_total;
        logic [3:0]       used_slots;
    } t_rsp;

    // one slot of the table
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [CNT_W-1:0]   count;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    // per-field write enables of the slot memory
    typedef struct packed {
        logic key;
        logic count;
        logic stamp;
    } t_mem_we;

    // scan outcome flags
    typedef struct packed {
        logic match;
        logic free;
    } t_scan_flags;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

@@ src/alkt_mem.sv @@
// ----------------------------------------------------------------------------
// alkt_mem: slot storage
// Key, count and stamp arrays with one write port (per-field enables)
// and one registered read port.
// ----------------------------------------------------------------------------
module alkt_mem #(
    parameter int ENTRIES = alkt_pkg::ENTRIES_DEF,
    localparam int IDX_W  = $clog2(ENTRIES)
) (
    input  logic                   i_clk,
    input  logic [IDX_W-1:0]       i_rd_addr,
    output alkt_pkg::t_entry       o_rd_data,
    input  alkt_pkg::t_mem_we      i_wr_en,
    input  logic [IDX_W-1:0]       i_wr_addr,
    input  alkt_pkg::t_entry       i_wr_data
);

    logic [alkt_pkg::KEY_W-1:0]   r_key_mem   [ENTRIES];
    logic [alkt_pkg::CNT_W-1:0]   r_count_mem [ENTRIES];
    logic [alkt_pkg::STAMP_W-1:0] r_stamp_mem [ENTRIES];
    alkt_pkg::t_entry             r_rd_data;

    // write selected fields
    always_ff @(posedge i_clk) begin
        if (i_wr_en.key) begin
            r_key_mem[i_wr_addr] <= i_wr_data.key;
        end
        if (i_wr_en.count) begin
            r_count_mem[i_wr_addr] <= i_wr_data.count;
        end
        if (i_wr_en.stamp) begin
            r_stamp_mem[i_wr_addr] <= i_wr_data.stamp;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rd_data.key   <= r_key_mem[i_rd_addr];
        r_rd_data.count <= r_count_mem[i_rd_addr];
        r_rd_data.stamp <= r_stamp_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/alkt_scan.sv @@
// ----------------------------------------------------------------------------
// alkt_scan: slot compare unit
// Takes one slot per cycle and tracks the first key match, the first
// empty slot and the valid slot with the oldest stamp.
// ----------------------------------------------------------------------------
module alkt_scan #(
    parameter int ENTRIES = alkt_pkg::ENTRIES_DEF,
    localparam int IDX_W  = $clog2(ENTRIES)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_cmp_vld,
    input  logic [IDX_W-1:0]            i_cmp_idx,
    input  logic                        i_valid_bit,
    input  alkt_pkg::t_entry            i_entry,
    input  logic [alkt_pkg::KEY_W-1:0]  i_key,
    output alkt_pkg::t_scan_flags       o_flags,
    output logic [IDX_W-1:0]            o_match_idx,
    output logic [alkt_pkg::CNT_W-1:0]  o_match_count,
    output logic [IDX_W-1:0]            o_free_idx,
    output logic [IDX_W-1:0]            o_lru_idx
);

    alkt_pkg::t_scan_flags          r_flags;
    logic                           r_have_lru;
    logic [IDX_W-1:0]               r_match_idx;
    logic [alkt_pkg::CNT_W-1:0]     r_match_count;
    logic [IDX_W-1:0]               r_free_idx;
    logic [IDX_W-1:0]               r_lru_idx;
    logic [alkt_pkg::STAMP_W-1:0]   r_lru_stamp;
    logic                           w_key_eq;
    logic                           w_older;

    // the shared comparators
    assign w_key_eq = (i_entry.key == i_key);
    assign w_older  = (i_entry.stamp < r_lru_stamp);

    // track match, first empty slot and oldest valid slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags    <= '0;
            r_have_lru <= 1'b0;
        end else if (i_start) begin
            r_flags    <= '0;
            r_have_lru <= 1'b0;
        end else if (i_cmp_vld) begin
            if (i_valid_bit && w_key_eq && !r_flags.match) begin
                r_flags.match <= 1'b1;
                r_match_idx   <= i_cmp_idx;
                r_match_count <= i_entry.count;
            end
            if (!i_valid_bit && !r_flags.free) begin
                r_flags.free <= 1'b1;
                r_free_idx   <= i_cmp_idx;
            end
            // strict compare keeps the lowest index on a tie
            if (i_valid_bit && (!r_have_lru || w_older)) begin
                r_have_lru  <= 1'b1;
                r_lru_stamp <= i_entry.stamp;
                r_lru_idx   <= i_cmp_idx;
            end
        end
    end

    assign o_flags       = r_flags;
    assign o_match_idx   = r_match_idx;
    assign o_match_count = r_match_count;
    assign o_free_idx    = r_free_idx;
    assign o_lru_idx     = r_lru_idx;

endmodule

@@ src/assoc_lru_key_table_core.sv @@
// ----------------------------------------------------------------------------
// assoc_lru_key_table_core: fully associative key table with LRU refill
// Lookup, store and invalidate-all on 64-bit keys with saturating
// statistics, one response per request.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel i_valid / o_stall carries i_req (action, key, token
//   count). A request is taken at a clock edge with i_valid high and
//   o_stall low. Response channel o_valid / i_stall carries o_rsp and is
//   taken at an edge with o_valid high and i_stall low.
//   Lookup and store scan the slot memory one slot per cycle through a
//   single compare unit, fed by the memory's registered read; the scan
//   then passes the last-slot step (S_LAST) and the resolve step
//   (S_FIN), which loads the response register. Invalidate-all and
//   unused action codes go straight to the resolve step. o_stall is
//   high while a request is in work; the next request is taken the
//   cycle after the response is loaded, so no request overlaps another.
//   The response sits in an output register; a new request may be taken
//   while it waits. If the receiver still stalls when the next response
//   is ready, that response holds back until the register drains.
//   Reset (i_rst_n low, synchronous) clears all valid bits, the
//   statistics and the response register, and sets the stamp counter to
//   one. No clearing pass is needed.
// ----------------------------------------------------------------------------
module assoc_lru_key_table_core #(
    parameter int ENTRIES = alkt_pkg::ENTRIES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  alkt_pkg::t_req  i_req,
    output logic            o_valid,
    input  logic            i_stall,
    output alkt_pkg::t_rsp  o_rsp
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int VCNT_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_FIN
    } t_state;

    t_state                         r_state;
    alkt_pkg::t_req                 r_req;
    logic [IDX_W-1:0]               r_rd_addr;
    logic                           r_cmp_vld;
    logic [IDX_W-1:0]               r_cmp_idx;
    logic [ENTRIES-1:0]             r_valid;
    logic [VCNT_W-1:0]              r_valid_cnt;
    logic [alkt_pkg::STAMP_W-1:0]   r_stamp_ctr;
    logic [alkt_pkg::CNT_W-1:0]     r_lookups;
    logic [alkt_pkg::CNT_W-1:0]     r_hits;
    logic [alkt_pkg::CNT_W-1:0]     r_stores;
    logic [alkt_pkg::CNT_W-1:0]     r_evicts;
    logic                           r_out_vld;
    alkt_pkg::t_rsp                 r_rsp;

    logic [ENTRIES-1:0]             n_valid;
    logic [VCNT_W-1:0]              n_valid_cnt;
    logic [alkt_pkg::STAMP_W-1:0]   n_stamp_ctr;
    logic [alkt_pkg::CNT_W-1:0]     n_lookups;
    logic [alkt_pkg::CNT_W-1:0]     n_hits;
    logic [alkt_pkg::CNT_W-1:0]     n_stores;
    logic [alkt_pkg::CNT_W-1:0]     n_evicts;
    alkt_pkg::t_rsp                 n_rsp;

    logic                           w_accept;
    logic                           w_fire;
    logic [alkt_pkg::STAMP_W-1:0]   w_stamp_inc;
    logic [IDX_W-1:0]               w_victim;
    alkt_pkg::t_mem_we              w_we;
    alkt_pkg::t_mem_we              w_wr_en;
    logic [IDX_W-1:0]               w_wr_addr;
    alkt_pkg::t_entry               w_wr_data;
    alkt_pkg::t_entry               w_rd_data;
    alkt_pkg::t_scan_flags          w_flags;
    logic [IDX_W-1:0]               w_match_idx;
    logic [alkt_pkg::CNT_W-1:0]     w_match_count;
    logic [IDX_W-1:0]               w_free_idx;
    logic [IDX_W-1:0]               w_lru_idx;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_fire   = (r_state == S_FIN) && (!r_out_vld || !i_stall);

    assign w_stamp_inc = r_stamp_ctr + alkt_pkg::STAMP_W'(1);
    assign w_victim    = w_flags.free ? w_free_idx : w_lru_idx;

    // slot storage
    alkt_mem #(
        .ENTRIES    (ENTRIES)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rd_addr  (r_rd_addr),
        .o_rd_data  (w_rd_data),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (w_wr_addr),
        .i_wr_data  (w_wr_data)
    );

    // compare unit
    alkt_scan #(
        .ENTRIES        (ENTRIES)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_accept),
        .i_cmp_vld      (r_cmp_vld),
        .i_cmp_idx      (r_cmp_idx),
        .i_valid_bit    (r_valid[r_cmp_idx]),
        .i_entry        (w_rd_data),
        .i_key          (r_req.key),
        .o_flags        (w_flags),
        .o_match_idx    (w_match_idx),
        .o_match_count  (w_match_count),
        .o_free_idx     (w_free_idx),
        .o_lru_idx      (w_lru_idx)
    );

    // resolve the request once the scan is done
    always_comb begin
        n_valid     = r_valid;
        n_valid_cnt = r_valid_cnt;
        n_stamp_ctr = r_stamp_ctr;
        n_lookups   = r_lookups;
        n_hits      = r_hits;
        n_stores    = r_stores;
        n_evicts    = r_evicts;
        n_rsp       = '0;
        w_we        = '0;
        w_wr_addr   = w_match_idx;
        w_wr_data.key   = r_req.key;
        w_wr_data.count = r_req.token_count;
        w_wr_data.stamp = w_stamp_inc;

        unique case (r_req.action)
            alkt_pkg::ACT_LOOKUP: begin
                n_lookups = alkt_pkg::sat_inc(r_lookups);
                if (w_flags.match) begin
                    w_we.stamp        = 1'b1;
                    n_stamp_ctr       = w_stamp_inc;
                    n_hits            = alkt_pkg::sat_inc(r_hits);
                    n_rsp.hit         = 1'b1;
                    n_rsp.found_count = w_match_count;
                    n_rsp.slot_index  = 3'(w_match_idx);
                end
            end
            alkt_pkg::ACT_STORE: begin
                n_stamp_ctr = w_stamp_inc;
                if (w_flags.match) begin
                    w_we.count       = 1'b1;
                    w_we.stamp       = 1'b1;
                    n_rsp.hit        = 1'b1;
                    n_rsp.slot_index = 3'(w_match_idx);
                end else begin
                    w_we              = '1;
                    w_wr_addr         = w_victim;
                    n_valid[w_victim] = 1'b1;
                    n_stores          = alkt_pkg::sat_inc(r_stores);
                    n_rsp.slot_index  = 3'(w_victim);
                    if (w_flags.free) begin
                        n_valid_cnt = r_valid_cnt + VCNT_W'(1);
                    end else begin
                        n_rsp.evicted = 1'b1;
                        n_evicts      = alkt_pkg::sat_inc(r_evicts);
                    end
                end
            end
            alkt_pkg::ACT_INVAL: begin
                n_valid     = '0;
                n_valid_cnt = '0;
            end
            default: begin
            end
        endcase

        n_rsp.lookup_total   = n_lookups;
        n_rsp.hit_total      = n_hits;
        n_rsp.store_total    = n_stores;
        n_rsp.eviction_total = n_evicts;
        n_rsp.used_slots     = 4'(n_valid_cnt);
    end

    // gate memory writes to the resolve cycle
    assign w_wr_en = w_fire ? w_we : '0;

    // sequencer, table state, statistics and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_addr   <= '0;
            r_cmp_vld   <= 1'b0;
            r_valid     <= '0;
            r_valid_cnt <= '0;
            r_stamp_ctr <= alkt_pkg::STAMP_W'(1);
            r_lookups   <= '0;
            r_hits      <= '0;
            r_stores    <= '0;
            r_evicts    <= '0;
            r_out_vld   <= 1'b0;
            r_rsp       <= '0;
        end else begin
            // load a new response, or drop the current one once taken
            if (w_fire) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    r_cmp_vld <= 1'b0;
                    if (w_accept) begin
                        r_req     <= i_req;
                        r_rd_addr <= '0;
                        if (i_req.action == alkt_pkg::ACT_LOOKUP ||
                            i_req.action == alkt_pkg::ACT_STORE) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_SCAN: begin
                    // advance the read address one slot per cycle
                    r_cmp_vld <= 1'b1;
                    r_cmp_idx <= r_rd_addr;
                    if (r_rd_addr == LAST_ADDR) begin
                        r_state <= S_LAST;
                    end else begin
                        r_rd_addr <= r_rd_addr + IDX_W'(1);
                    end
                end
                S_LAST: begin
                    r_cmp_vld <= 1'b0;
                    r_state   <= S_FIN;
                end
                S_FIN: begin
                    if (w_fire) begin
                        r_valid     <= n_valid;
                        r_valid_cnt <= n_valid_cnt;
                        r_stamp_ctr <= n_stamp_ctr;
                        r_lookups   <= n_lookups;
                        r_hits      <= n_hits;
                        r_stores    <= n_stores;
                        r_evicts    <= n_evicts;
                        r_rsp       <= n_rsp;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_vld;
    assign o_rsp   = r_rsp;

`ifndef SYNTH
    // valid count tracks the valid bits
    a_valid_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_valid_cnt) == $countones(r_valid))
        else $error("valid slot count out of step with valid bits");

    // a response is loaded only from the resolve step
    a_rsp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state) == S_FIN)
        else $error("response loaded outside resolve step");

    // hits never exceed lookups
    a_hit_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.hit_total <= o_rsp.lookup_total)
        else $error("hit total above lookup total");

    // evictions never exceed stores
    a_evict_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.eviction_total <= o_rsp.store_total)
        else $error("eviction total above store total");

    // a stalled response stays valid until the receiver takes it
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |=> r_out_vld)
        else $error("stalled response lost");
`endif

endmodule
